@@ rtl/bdbp_pkg.sv @@
// Shared types, codes and constants for the data-section bit packer.
`timescale 1ns / 1ps
`default_nettype none
package bdbp_pkg;

  localparam int MAX_FIELD_BITS = 32;
  localparam int WIDTH_LIMIT    = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam int WORD_BITS      = 40;
  localparam int IN_DATA_BITS   = 48;
  localparam int OUT_DATA_BITS  = 40;

  typedef enum logic [2:0] {
    ACT_NUMERIC   = 3'd0,
    ACT_MISSING   = 3'd1,
    ACT_RAW       = 3'd2,
    ACT_SET_WIDTH = 3'd3,
    ACT_END       = 3'd4
  } action_t;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TOO_WIDE  = 2'd1;
  localparam logic [1:0] ERR_BAD_WIDTH = 2'd2;

  localparam logic [7:0] WIDTH_BIAS = 8'd128;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [2:0]           nbytes;
    logic [1:0]           err;
    logic                 is_end;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/bufr_data_bit_packer.sv @@
// Top level of the MSB-first variable-width data-section bit packer.
//
// Input stream (s_axis_*): one item per field - numeric, missing, raw bits,
// set width change or end of section. Output stream (m_axis_*): one result per
// completed byte, or one status result for an item that completes no byte;
// tlast marks the final result of each item, tuser flags a real byte.
// cfg_wr_en/cfg_wr_data set the start parity of the section's byte offset;
// write it only while the block is idle.
// Items pass the command queue and the current-command register before their
// results are registered at the output. The emitter gives one result per
// cycle while the receiver takes them; an item yields 1 to 4 results, set by
// its byte count (up to four bytes from a 32-bit field plus carried bits).
// The front end accepts one item per cycle while the four-entry queue has room.
// Reset clears the packing state, byte count, width change, start parity and
// queue. When the receiver stalls the output register holds, the emitter
// waits, the queue fills and s_axis_tready falls.
`timescale 1ns / 1ps
`default_nettype none
module bufr_data_bit_packer
  import bdbp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_wr_en,
  input  wire logic                     cfg_wr_data,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // action[2:0], value[34:3], bit_len[40:35], zero fill
  input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // out_byte[7:0], error[9:8], section_length[33:10], zero fill
  output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,
  // is_byte
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);

  cmd_t        front_cmd;
  cmd_t        q_head;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        push;
  logic [7:0]  out_byte;
  logic [1:0]  error;
  logic [23:0] section_length;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  bdbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .action      (s_axis_tdata[2:0]),
    .value       (s_axis_tdata[34:3]),
    .bit_len     (s_axis_tdata[40:35]),
    .cmd         (front_cmd)
  );

  bdbp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  bdbp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_byte       (out_byte),
    .is_byte        (m_axis_tuser),
    .error          (error),
    .section_length (section_length),
    .last           (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, section_length, error, out_byte};

endmodule
`default_nettype wire

@@ rtl/bdbp_front.sv @@
// Front end: accepts items, checks widths and packs bits into byte commands.
`timescale 1ns / 1ps
`default_nettype none
module bdbp_front
  import bdbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        push,
  input  wire logic [2:0]  action,
  input  wire logic [31:0] value,
  input  wire logic [5:0]  bit_len,
  output cmd_t             cmd
);

  logic              start_parity;
  logic [6:0]        partial_bits;
  logic [2:0]        partial_count;
  logic [7:0]        width_change;
  logic              count_parity;

  logic [6:0]        partial_bits_next;
  logic [2:0]        partial_count_next;
  logic [7:0]        width_change_next;
  logic              count_parity_next;

  logic signed [8:0] eff;
  logic              eff_ok;
  logic              base_ok;
  logic [5:0]        n;
  logic [32:0]       mask;
  logic [32:0]       vsrc;
  logic [32:0]       vm;
  logic              fits;
  logic [WORD_BITS-1:0] acc;
  logic [5:0]        total;
  logic [7:0]        rem_mask;
  logic              has_pad;
  logic              add_zero;
  logic [7:0]        pad_byte;

  always_comb begin
    eff      = $signed({3'b000, bit_len}) + $signed({width_change[7], width_change});
    eff_ok   = (eff >= 9'sd1) && (eff <= $signed(9'(WIDTH_LIMIT)));
    base_ok  = (bit_len >= 6'd1) && (bit_len <= 6'(WIDTH_LIMIT));
    n        = (action == ACT_NUMERIC) ? eff[5:0] : bit_len;
    mask     = (33'd1 << n) - 33'd1;
    vsrc     = (action == ACT_MISSING) ? {1'b0, 32'hffff_ffff} : {1'b0, value};
    vm       = vsrc & mask;
    fits     = (({1'b0, value} & ~mask) == 33'd0);
    acc      = ({33'd0, partial_bits} << n) | {7'd0, vm};
    total    = {3'd0, partial_count} + n;
    rem_mask = (8'd1 << total[2:0]) - 8'd1;
    has_pad  = (partial_count != 3'd0);
    pad_byte = 8'({1'b0, partial_bits} << (4'd8 - {1'b0, partial_count}));
    add_zero = start_parity ^ count_parity ^ has_pad;

    partial_bits_next  = partial_bits;
    partial_count_next = partial_count;
    width_change_next  = width_change;
    count_parity_next  = count_parity;
    cmd.word   = '0;
    cmd.nbytes = 3'd0;
    cmd.err    = ERR_NONE;
    cmd.is_end = 1'b0;

    unique case (action)
      ACT_NUMERIC, ACT_MISSING, ACT_RAW: begin
        if ((action == ACT_NUMERIC) ? !eff_ok : !base_ok) begin
          cmd.err = ERR_BAD_WIDTH;
        end else if ((action == ACT_NUMERIC) && !fits) begin
          cmd.err = ERR_TOO_WIDE;
        end else begin
          cmd.word           = acc << (6'd40 - total);
          cmd.nbytes         = total[5:3];
          partial_bits_next  = acc[6:0] & rem_mask[6:0];
          partial_count_next = total[2:0];
          count_parity_next  = count_parity ^ total[3];
        end
      end
      ACT_SET_WIDTH: begin
        width_change_next = value[7:0] - WIDTH_BIAS;
      end
      ACT_END: begin
        cmd.is_end         = 1'b1;
        cmd.word           = {pad_byte, 32'd0};
        cmd.nbytes         = {1'b0, has_pad & add_zero, has_pad ^ add_zero};
        partial_bits_next  = '0;
        partial_count_next = '0;
        width_change_next  = '0;
        count_parity_next  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_parity  <= 1'b0;
      partial_bits  <= '0;
      partial_count <= '0;
      width_change  <= '0;
      count_parity  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        start_parity <= cfg_wr_data;
      end
      if (push) begin
        partial_bits  <= partial_bits_next;
        partial_count <= partial_count_next;
        width_change  <= width_change_next;
        count_parity  <= count_parity_next;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/bdbp_fifo.sv @@
// Short command queue between the front end and the byte emitter.
`timescale 1ns / 1ps
`default_nettype none
module bdbp_fifo
  import bdbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full      = (count == CNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_BITS'(push) - CNT_BITS'(pop);
    end
  end

endmodule
`default_nettype wire

@@ rtl/bdbp_back.sv @@
// Back end: emits one result per cycle, when the output is not stalled, from queued commands and counts bytes.
`timescale 1ns / 1ps
`default_nettype none
module bdbp_back
  import bdbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  cmd_t             q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             is_byte,
  output logic [1:0]       error,
  output logic [23:0]      section_length,
  output logic             last
);

  logic                 cur_valid;
  logic [WORD_BITS-1:0] cur_word;
  logic [2:0]           cur_left;
  logic [1:0]           cur_err;
  logic                 cur_end;
  logic [23:0]          byte_count;
  logic [23:0]          byte_count_next;
  logic                 emit;
  logic                 done;

  always_comb begin
    emit            = cur_valid && (!out_valid || out_ready);
    done            = (cur_left == 3'd0) || (cur_left == 3'd1);
    byte_count_next = (cur_left == 3'd0) ? byte_count : byte_count + 24'd1;
    q_pop           = q_valid && (!cur_valid || (emit && done));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      out_valid  <= 1'b0;
      byte_count <= '0;
    end else begin
      if (emit) begin
        out_valid  <= 1'b1;
        byte_count <= (done && cur_end) ? 24'd0 : byte_count_next;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (emit && done) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte       <= (cur_left == 3'd0) ? 8'd0 : cur_word[WORD_BITS-1 -: 8];
      is_byte        <= (cur_left != 3'd0);
      error          <= cur_err;
      section_length <= byte_count_next;
      last           <= done;
    end
    if (q_pop) begin
      cur_word <= q_head.word;
      cur_left <= q_head.nbytes;
      cur_err  <= q_head.err;
      cur_end  <= q_head.is_end;
    end else if (emit) begin
      cur_word <= cur_word << 8;
      cur_left <= (cur_left == 3'd0) ? 3'd0 : cur_left - 3'd1;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/bufr_data_bit_packer_tb.sv @@
// Self-checking testbench for the MSB-first data-section bit packer.
`timescale 1ns / 1ps
module bufr_data_bit_packer_tb;
  import bdbp_pkg::*;

  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int         DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_byte;
    logic [1:0]  err;
    logic [23:0] sec_len;
    logic        last;
  } packed_result_t;

  logic                     clk           = 1'b0;
  logic                     rst           = 1'b1;
  logic                     cfg_wr_en     = 1'b0;
  logic                     cfg_wr_data   = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tuser;
  logic                     m_axis_tlast;

  logic        start_par  = 1'b0;
  logic [6:0]  held_bits  = '0;
  logic [2:0]  held_count = '0;
  logic [7:0]  width_step = '0;
  logic [23:0] sec_bytes  = '0;

  packed_result_t due_results[$];
  int mismatches    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  bufr_data_bit_packer u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic void emit_byte(input logic [7:0] b);
    sec_bytes = sec_bytes + 24'd1;
    due_results.push_back(packed_result_t'{b, 1'b1, ERR_NONE, sec_bytes, 1'b0});
  endfunction

  function automatic void pack_item(input logic [2:0] act, input logic [31:0] val,
                                    input logic [5:0] len);
    int             n;
    int             total;
    int             first;
    logic [1:0]     code;
    logic [31:0]    bits;
    logic [63:0]    acc;
    logic [7:0]     tail;
    packed_result_t r;
    n     = 0;
    code  = ERR_NONE;
    bits  = val;
    first = due_results.size();
    case (act)
      ACT_NUMERIC: begin
        n = int'(len) + int'($signed(width_step));
        if (n < 1 || n > WIDTH_LIMIT) code = ERR_BAD_WIDTH;
        else if ((64'(val) >> n) != 64'd0) code = ERR_TOO_WIDE;
      end
      ACT_MISSING, ACT_RAW: begin
        n = int'(len);
        if (n < 1 || n > WIDTH_LIMIT) code = ERR_BAD_WIDTH;
        if (act == ACT_MISSING) bits = '1;
      end
      ACT_SET_WIDTH: width_step = val[7:0] - WIDTH_BIAS;
      ACT_END: begin
        if (held_count != 3'd0) begin
          tail = {1'b0, held_bits};
          tail = tail << (8 - int'(held_count));
          emit_byte(tail);
        end
        if ((start_par ^ sec_bytes[0]) != 1'b0) emit_byte(8'd0);
      end
      default: ;
    endcase
    if (code == ERR_NONE && n > 0) begin
      total = int'(held_count) + n;
      acc   = (64'(held_bits) << n) | (64'(bits) & ((64'd1 << n) - 64'd1));
      while (total >= 8) begin
        emit_byte(8'(acc >> (total - 8)));
        total -= 8;
      end
      held_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
      held_count = 3'(total);
    end
    if (due_results.size() == first) begin
      due_results.push_back(packed_result_t'{8'd0, 1'b0, code, sec_bytes, 1'b1});
    end else begin
      r      = due_results.pop_back();
      r.last = 1'b1;
      due_results.push_back(r);
    end
    if (act == ACT_END) begin
      held_bits  = '0;
      held_count = '0;
      width_step = '0;
      sec_bytes  = '0;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    packed_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing due: expected none, actual tdata=%h tuser=%b tlast=%b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = due_results.pop_front();
        compare_field("out_byte", 24'(want.out_byte), 24'(m_axis_tdata[7:0]));
        compare_field("is_byte", 24'(want.is_byte), 24'(m_axis_tuser));
        compare_field("error", 24'(want.err), 24'(m_axis_tdata[9:8]));
        compare_field("section_length", want.sec_len, m_axis_tdata[33:10]);
        compare_field("last", 24'(want.last), 24'(m_axis_tlast));
      end
    end
  end

  task automatic send_item(input logic [2:0] act, input logic [31:0] val,
                           input logic [5:0] len);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, len, val, act};
    do @(posedge clk); while (!s_axis_tready);
    pack_item(act, val, len);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_start_parity(input logic p);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    start_par = p;
  endtask

  task automatic test_directed_fields();
    send_idle_pct = 11;
    recv_idle_pct = 87;
    send_item(ACT_NUMERIC, 32'd0, 6'd1);
    send_item(ACT_NUMERIC, 32'hFFFF_FFFF, 6'd32);
    send_item(ACT_NUMERIC, 32'd2, 6'd1);
    send_item(ACT_NUMERIC, 32'd0, 6'd0);
    send_item(ACT_NUMERIC, 32'd0, 6'd33);
    send_item(ACT_MISSING, 32'd0, 6'd32);
    send_item(ACT_MISSING, 32'd0, 6'd0);
    send_item(ACT_RAW, 32'd0, 6'd63);
    send_item(ACT_RAW, 32'hABCD_EF12, 6'd6);
    send_item(ACT_NUMERIC, 32'h8000_0001, 6'd32);
    send_item(ACT_SET_WIDTH, 32'd255, 6'd0);
    send_item(ACT_NUMERIC, 32'd0, 6'd1);
    send_item(ACT_SET_WIDTH, 32'hFFFF_FF00, 6'd0);
    send_item(ACT_NUMERIC, 32'd0, 6'd63);
    send_item(ACT_SET_WIDTH, 32'd127, 6'd0);
    send_item(ACT_NUMERIC, 32'd0, 6'd1);
    send_item(ACT_NUMERIC, 32'hFFFF_FFFF, 6'd33);
    send_item(ACT_NUMERIC, 32'd1, 6'd2);
    send_item(ACT_SPARE_LO, 32'hFFFF_FFFF, 6'd63);
    send_item(ACT_SPARE_HI, 32'hFFFF_FFFF, 6'd63);
    send_item(ACT_END, 32'd0, 6'd0);
    send_item(ACT_END, 32'd0, 6'd0);
  endtask

  task automatic test_start_parity();
    set_start_parity(1'b1);
    send_item(ACT_END, 32'd0, 6'd0);
    send_item(ACT_RAW, 32'h5A, 6'd8);
    send_item(ACT_END, 32'd0, 6'd0);
    send_item(ACT_RAW, 32'hFFFF_FFFF, 6'd4);
    send_item(ACT_END, 32'd0, 6'd0);
    set_start_parity(1'b0);
    send_item(ACT_RAW, 32'h5, 6'd3);
    send_item(ACT_END, 32'd0, 6'd0);
  endtask

  task automatic test_random_stream(input int send_pct, input int recv_pct, input int count,
                                    input bit pause_midway);
    int          pick;
    int          wc;
    int          lo;
    int          hi;
    int          len_i;
    int          eff;
    logic [2:0]  act;
    logic [31:0] val;
    logic [5:0]  len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) drain_results();
      pick = $urandom_range(0, 99);
      wc   = int'($signed(width_step));
      lo   = (1 - wc > 0) ? 1 - wc : 0;
      hi   = (32 - wc < 63) ? 32 - wc : 63;
      len  = 6'($urandom_range(1, 32));
      val  = $urandom;
      act  = ACT_NUMERIC;
      if (pick < 55 || (pick >= 90 && pick < 94)) begin
        if (pick >= 90) hi = hi - 1;
        if (lo > hi) begin
          act = ACT_SET_WIDTH;
          val = 32'(WIDTH_BIAS);
        end else begin
          case ($urandom_range(0, 3))
            0: len_i = lo;
            1: len_i = hi;
            default: len_i = $urandom_range(lo, hi);
          endcase
          eff = len_i + wc;
          len = 6'(len_i);
          if (pick < 55) val = val & 32'((64'd1 << eff) - 64'd1);
          else val = val | (32'd1 << eff);
        end
      end else if (pick < 65) begin
        act = ACT_MISSING;
      end else if (pick < 75) begin
        act = ACT_RAW;
      end else if (pick < 83) begin
        act = ACT_SET_WIDTH;
        val = 32'(WIDTH_BIAS) + $urandom_range(0, 8) - 32'd4;
      end else if (pick < 90) begin
        act = ACT_END;
      end else if (pick < 97) begin
        act = 3'($urandom_range(0, 2));
        len = ($urandom_range(0, 1) != 0) ? 6'd0 : 6'($urandom_range(33, 63));
      end else if (pick < 98) begin
        act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      end else begin
        act = ACT_SET_WIDTH;
      end
      send_item(act, val, len);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_fields();
    test_start_parity();
    test_random_stream(11, 87, 45, 1'b1);
    set_start_parity(1'b1);
    test_random_stream(87, 11, 45, 1'b0);
    set_start_parity(1'b0);
    test_random_stream(0, 0, 45, 1'b0);
    drain_results();
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("bufr_data_bit_packer test passed");
    end else begin
      $display("bufr_data_bit_packer test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("bufr_data_bit_packer test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bdbp_pkg.sv
rtl/bdbp_front.sv
rtl/bdbp_fifo.sv
rtl/bdbp_back.sv
rtl/bufr_data_bit_packer.sv
tb/sv/bufr_data_bit_packer_tb.sv
